[hw/rtl/bfts_pkg.sv]
// Shared types and constants for the box-filtered texture sampler.
package bfts_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE     = 2'd0,
    CMD_SAMPLE_2D = 2'd1,
    CMD_SAMPLE_1D = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_BOUND,
    ST_WALK,
    ST_DRAIN,
    ST_START,
    ST_DIV
  } state_e;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 9;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam int unsigned NumChan = 4;

endpackage

[hw/rtl/bfts_if.sv]
// Channel interfaces: sample/write requests, results and configuration writes.
interface bfts_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [17:0] coord_u;
  logic signed [17:0] coord_v;
  logic [2:0]         radius;
  logic [7:0]         pixel_x;
  logic [7:0]         pixel_y;
  logic [7:0]         red_in;
  logic [7:0]         green_in;
  logic [7:0]         blue_in;
  logic [7:0]         alpha_in;

  modport source (output valid, command, coord_u, coord_v, radius, pixel_x, pixel_y,
                  red_in, green_in, blue_in, alpha_in, input ready);
  modport sink (input valid, command, coord_u, coord_v, radius, pixel_x, pixel_y,
                red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface bfts_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_avg;
  logic [15:0] green_avg;
  logic [15:0] blue_avg;
  logic [15:0] alpha_avg;
  logic [7:0]  pixels_counted;

  modport source (output valid, red_avg, green_avg, blue_avg, alpha_avg, pixels_counted,
                  input ready);
  modport sink (input valid, red_avg, green_avg, blue_avg, alpha_avg, pixels_counted,
                output ready);
endinterface

interface bfts_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/bfts_mem.sv]
// Pixel memory: one write port and one read port with registered read data.
module bfts_mem import bfts_pkg::*; #(
  parameter int unsigned AW = 16,
  parameter int unsigned DW = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bfts_div.sv]
// Restoring divider, one quotient bit per cycle, one lane per color channel.
module bfts_div import bfts_pkg::*; #(
  parameter int unsigned DW = 24,
  parameter int unsigned CW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i [NumChan],
  input  logic [CW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quotient_o [NumChan]
);

  localparam int unsigned StepW = $clog2(DW + 1);

  logic [StepW-1:0] step_q, step_d;
  logic [CW-1:0]    div_q;
  logic [CW-1:0]    rem_q [NumChan];
  logic [CW-1:0]    rem_d [NumChan];
  logic [DW-1:0]    dq_q [NumChan];
  logic [DW-1:0]    dq_d [NumChan];

  always_comb begin
    logic [CW:0] rem_sh;
    logic        ge;
    for (int l = 0; l < NumChan; l++) begin
      rem_sh = {rem_q[l], dq_q[l][DW-1]};
      ge = rem_sh >= {1'b0, div_q};
      rem_d[l] = ge ? CW'(rem_sh - {1'b0, div_q}) : CW'(rem_sh);
      dq_d[l] = {dq_q[l][DW-2:0], ge};
    end
  end

  assign step_d = step_q - StepW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (start_i) begin
      step_q <= StepW'(DW);
    end else if (step_q != '0) begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      for (int l = 0; l < NumChan; l++) begin
        rem_q[l] <= '0;
        dq_q[l] <= dividend_i[l];
      end
    end else if (step_q != '0) begin
      for (int l = 0; l < NumChan; l++) begin
        rem_q[l] <= rem_d[l];
        dq_q[l] <= dq_d[l];
      end
    end
  end

  assign busy_o = step_q != '0;
  assign quotient_o = dq_q;

endmodule

[hw/rtl/box_filtered_texture_sampler_top.sv]
// Top level of the box-filtered texture sampler: control, window walk and output.
//
// Usage: item_i carries requests. A write request (command 0) stores one RGBA
// pixel at (pixel_y, pixel_x); positions beyond the memory are
// dropped. A sample request (command 1 = square window, 2 = line on row 0)
// scales coord_u/coord_v by the image size, clamps to the image, and averages
// all in-image pixels of the window. result_o returns one result per sample:
// per-channel means in Q8.8 and the number of pixels averaged.
// A sample passes through the scale, bound, walk, drain, start and divide states
// in that order before its result is registered; the walk covers the in-image
// window pixels (at most 225). The next request is taken in the
// cycle the result appears. The walk reads the pixel memory port one pixel a
// cycle; the divider then takes one quotient bit a cycle. One request is in work
// at a time.
// cfg_i writes image_width (index 0) and image_height (index 1), always ready.
// Reset sets both sizes to 256; the pixel memory is not cleared.
// A finished result waits in an output register; while the receiver stalls,
// the next request is still accepted and processed, and only its final
// hand-off waits for the register to empty.
module box_filtered_texture_sampler_top import bfts_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_RADIUS = 7
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bfts_item_if.sink    item_i,
  bfts_result_if.source result_o,
  bfts_cfg_if.sink     cfg_i
);

  localparam int unsigned XA = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YA = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned AW = XA + YA;
  localparam int unsigned SW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned SH = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PWU = 19 + SW;
  localparam int unsigned PWV = 19 + SH;
  localparam int unsigned XE = XA + 4;
  localparam int unsigned YE = YA + 4;
  localparam int unsigned CntMax = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int unsigned CNTW = $clog2(CntMax + 1);
  localparam int unsigned SUMW = $clog2(255 * CntMax + 1);
  localparam int unsigned DW = SUMW + 8;
  localparam logic [SW-1:0] WRst = SW'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
  localparam logic [SH-1:0] HRst = SH'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);

  state_e state_q, state_d;

  logic [SW-1:0] w_eff_q;
  logic [SH-1:0] h_eff_q;
  logic [31:0]   cfg_data_ext;

  logic signed [17:0] u_q, v_q;
  logic [2:0]         r_q;
  logic               is1d_q;
  logic signed [PWU-1:0] pu_q;
  logic signed [PWV-1:0] pv_q;

  logic [XA-1:0] xlo_q, xhi_q, x_q;
  logic [YA-1:0] ylo_q, yhi_q, y_q;
  logic [XA-1:0] xlo, xhi;
  logic [YA-1:0] ylo, yhi;

  logic [SUMW-1:0] sum_q [NumChan];
  logic [CNTW-1:0] cnt_q;
  logic            rd_vld_q;

  logic            out_vld_q, out_vld_d;
  logic [15:0]     avg_q [NumChan];
  logic [7:0]      cnt_out_q;

  logic            item_fire, is_sample, x_last, y_last;
  logic            div_start, div_busy, out_load, out_free;
  logic [DW-1:0]   dividend [NumChan];
  logic [DW-1:0]   quotient [NumChan];

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [31:0]     mem_wdata, mem_rdata;
  logic [31:0]     px_ext, py_ext;
  logic [2:0]      r_sat;

  // ---------------- configuration ----------------
  assign cfg_i.ready = 1'b1;
  assign cfg_data_ext = 32'(cfg_i.data);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_eff_q <= WRst;
      h_eff_q <= HRst;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_IMAGE_WIDTH) begin
        w_eff_q <= SW'((cfg_data_ext == 0) ? 1 :
                       ((cfg_data_ext > MAX_WIDTH) ? MAX_WIDTH : cfg_data_ext));
      end else if (cfg_i.index == CFG_IMAGE_HEIGHT) begin
        h_eff_q <= SH'((cfg_data_ext == 0) ? 1 :
                       ((cfg_data_ext > MAX_HEIGHT) ? MAX_HEIGHT : cfg_data_ext));
      end
    end
  end

  // ---------------- request intake ----------------
  assign item_i.ready = state_q == ST_IDLE;
  assign item_fire = item_i.valid && item_i.ready;
  assign is_sample = (item_i.command == CMD_SAMPLE_2D) || (item_i.command == CMD_SAMPLE_1D);

  assign px_ext = 32'(item_i.pixel_x);
  assign py_ext = 32'(item_i.pixel_y);
  assign mem_we = item_fire && (item_i.command == CMD_WRITE) &&
                  (px_ext < MAX_WIDTH) && (py_ext < MAX_HEIGHT);
  assign mem_waddr = {py_ext[YA-1:0], px_ext[XA-1:0]};
  assign mem_wdata = {item_i.alpha_in, item_i.blue_in, item_i.green_in, item_i.red_in};
  assign r_sat = (32'(item_i.radius) > MAX_RADIUS) ? 3'(MAX_RADIUS) : item_i.radius;

  // ---------------- window bounds ----------------
  always_comb begin
    logic [SW+1:0] qu;
    logic [SH+1:0] qv;
    logic [XA-1:0] cx;
    logic [YA-1:0] cy;
    logic [XE-1:0] cxe, hxe;
    logic [YE-1:0] cye, hye;
    qu = pu_q[PWU-2:16];
    qv = pv_q[PWV-2:16];
    // negative product truncates toward zero and then clamps to column 0
    if (pu_q[PWU-1]) begin
      cx = '0;
    end else if (32'(qu) >= 32'(w_eff_q)) begin
      cx = XA'(w_eff_q - SW'(1));
    end else begin
      cx = XA'(qu);
    end
    if (pv_q[PWV-1]) begin
      cy = '0;
    end else if (32'(qv) >= 32'(h_eff_q)) begin
      cy = YA'(h_eff_q - SH'(1));
    end else begin
      cy = YA'(qv);
    end
    cxe = XE'(cx);
    hxe = cxe + XE'(r_q);
    xlo = (cxe >= XE'(r_q)) ? XA'(cxe - XE'(r_q)) : '0;
    xhi = (hxe > XE'(w_eff_q) - XE'(1)) ? XA'(w_eff_q - SW'(1)) : XA'(hxe);
    cye = YE'(cy);
    hye = cye + YE'(r_q);
    if (is1d_q) begin
      ylo = '0;
      yhi = '0;
    end else begin
      ylo = (cye >= YE'(r_q)) ? YA'(cye - YE'(r_q)) : '0;
      yhi = (hye > YE'(h_eff_q) - YE'(1)) ? YA'(h_eff_q - SH'(1)) : YA'(hye);
    end
  end

  assign x_last = x_q == xhi_q;
  assign y_last = y_q == yhi_q;
  assign mem_re = state_q == ST_WALK;
  assign mem_raddr = {y_q, x_q};

  // ---------------- control ----------------
  assign out_free = !out_vld_q || result_o.ready;

  always_comb begin
    state_d = state_q;
    div_start = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (item_fire && is_sample) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: state_d = ST_BOUND;
      ST_BOUND: state_d = ST_WALK;
      ST_WALK: begin
        if (x_last && y_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_START;
      ST_START: begin
        div_start = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy && out_free) begin
          out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_vld_q <= mem_re;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_vld_d = out_load ? 1'b1 : ((result_o.valid && result_o.ready) ? 1'b0 : out_vld_q);

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (item_fire && is_sample) begin
          u_q <= item_i.coord_u;
          v_q <= item_i.coord_v;
          r_q <= r_sat;
          is1d_q <= item_i.command == CMD_SAMPLE_1D;
        end
      end
      ST_SCALE: begin
        pu_q <= PWU'(u_q) * PWU'($signed({1'b0, w_eff_q}));
        pv_q <= PWV'(v_q) * PWV'($signed({1'b0, h_eff_q}));
      end
      ST_BOUND: begin
        xlo_q <= xlo;
        xhi_q <= xhi;
        ylo_q <= ylo;
        yhi_q <= yhi;
        x_q <= xlo;
        y_q <= ylo;
      end
      ST_WALK: begin
        if (x_last) begin
          x_q <= xlo_q;
          y_q <= y_q + YA'(1);
        end else begin
          x_q <= x_q + XA'(1);
        end
      end
      default: ;
    endcase
  end

  // read data lands in the cycle after its address is presented
  always_ff @(posedge clk_i) begin
    if (state_q == ST_BOUND) begin
      cnt_q <= '0;
      for (int k = 0; k < NumChan; k++) begin
        sum_q[k] <= '0;
      end
    end else if (rd_vld_q) begin
      cnt_q <= cnt_q + CNTW'(1);
      for (int k = 0; k < NumChan; k++) begin
        sum_q[k] <= sum_q[k] + SUMW'(mem_rdata[8*k +: 8]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NumChan; k++) begin
      dividend[k] = {sum_q[k], 8'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    logic [31:0] cnt_ext;
    cnt_ext = 32'(cnt_q);
    if (out_load) begin
      cnt_out_q <= cnt_ext[7:0];
      for (int k = 0; k < NumChan; k++) begin
        avg_q[k] <= quotient[k][15:0];
      end
    end
  end

  assign result_o.valid = out_vld_q;
  assign result_o.red_avg = avg_q[0];
  assign result_o.green_avg = avg_q[1];
  assign result_o.blue_avg = avg_q[2];
  assign result_o.alpha_avg = avg_q[3];
  assign result_o.pixels_counted = cnt_out_q;

  // ---------------- units ----------------
  bfts_mem #(
    .AW(AW),
    .DW(32)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bfts_div #(
    .DW(DW),
    .CW(CNTW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (cnt_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // ---------------- assertions ----------------
  a_write_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == ST_IDLE)
    else $error("pixel write outside idle");

  a_read_data_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_WALK || state_q == ST_DRAIN))
    else $error("read data arrived outside the window walk");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_START |-> cnt_q != '0)
    else $error("divide started with zero pixel count");

  a_walk_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> (x_q >= xlo_q && x_q <= xhi_q && y_q >= ylo_q && y_q <= yhi_q))
    else $error("walk position left the window");

  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Testbench for the box-filtered texture sampler: request driver, mean predictor and checks.
module tb;
  import bfts_pkg::*;

  localparam int MaxWidth    = 256;
  localparam int MaxHeight   = 256;
  localparam int MaxRadius   = 7;
  localparam int MaxTexels   = MaxWidth * MaxHeight;
  localparam int DrainCycles = 300;
  localparam int SettleLimit = 20000;
  localparam int PhaseBudget = 138;

  localparam logic [1:0]         CmdUnused    = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;
  localparam logic signed [17:0] CoordMin     = 18'sh20000;
  localparam logic signed [17:0] CoordMax     = 18'sh1FFFF;

  typedef struct {
    logic [1:0]         command;
    logic signed [17:0] coord_u;
    logic signed [17:0] coord_v;
    logic [2:0]         radius;
    logic [7:0]         pixel_x;
    logic [7:0]         pixel_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } texel_req_t;

  typedef struct {
    logic [15:0] chan [NumChan];
    logic [7:0]  count;
  } box_mean_t;

  typedef struct {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } reg_write_t;

  typedef enum {FLOW_OPEN, FLOW_LIGHT, FLOW_HEAVY} sink_flow_e;

  // Mirror of the texture memory and size registers, plus the queue of means in flight.
  class box_mean_board;
    bit [31:0]  texel [MaxTexels];
    bit         written [MaxTexels];
    logic [8:0] width_raw;
    logic [8:0] height_raw;
    box_mean_t  pending [$];
    int         errors;

    function new();
      width_raw  = 9'd256;
      height_raw = 9'd256;
      errors     = 0;
    endfunction

    function void set_register(reg_write_t wr);
      if (wr.index == CFG_IMAGE_WIDTH) width_raw = wr.data;
      else if (wr.index == CFG_IMAGE_HEIGHT) height_raw = wr.data;
    endfunction

    function int clamp_size(logic [8:0] raw, int limit);
      int s;
      s = int'(raw);
      if (s < 1) s = 1;
      if (s > limit) s = limit;
      return s;
    endfunction

    // Q2.16 times size, truncated toward zero, then held inside the image
    function int scale_coord(logic signed [17:0] c, int size);
      longint p;
      longint q;
      p = longint'(c) * longint'(size);
      if (p < 0) q = -((-p) >>> 16);
      else q = p >>> 16;
      if (q < 0) q = 0;
      if (q >= size) q = size - 1;
      return int'(q);
    endfunction

    // In-image part of the window, inclusive bounds
    function void window(texel_req_t rq, output int x0, output int x1,
                         output int y0, output int y1);
      int w;
      int h;
      int r;
      int cx;
      int cy;
      w = clamp_size(width_raw, MaxWidth);
      h = clamp_size(height_raw, MaxHeight);
      r = int'(rq.radius);
      if (r > MaxRadius) r = MaxRadius;
      cx = scale_coord(rq.coord_u, w);
      x0 = (cx - r < 0) ? 0 : cx - r;
      x1 = (cx + r > w - 1) ? w - 1 : cx + r;
      if (rq.command == CMD_SAMPLE_2D) begin
        cy = scale_coord(rq.coord_v, h);
        y0 = (cy - r < 0) ? 0 : cy - r;
        y1 = (cy + r > h - 1) ? h - 1 : cy + r;
      end else begin
        y0 = 0;
        y1 = 0;
      end
    endfunction

    function void missing_texels(texel_req_t rq, output int unsigned holes[$]);
      int x0;
      int x1;
      int y0;
      int y1;
      window(rq, x0, x1, y0, y1);
      for (int x = x0; x <= x1; x++)
        for (int y = y0; y <= y1; y++)
          if (!written[y * MaxWidth + x]) holes.push_back(y * MaxWidth + x);
    endfunction

    function void take_request(texel_req_t rq);
      int x0;
      int x1;
      int y0;
      int y1;
      int unsigned addr;
      int unsigned n;
      int unsigned sum [NumChan];
      bit [31:0] word;
      box_mean_t m;
      if (rq.command == CMD_WRITE) begin
        if (rq.pixel_x < MaxWidth && rq.pixel_y < MaxHeight) begin
          addr = int'(rq.pixel_y) * MaxWidth + int'(rq.pixel_x);
          texel[addr]   = {rq.alpha, rq.blue, rq.green, rq.red};
          written[addr] = 1'b1;
        end
        return;
      end
      if (rq.command != CMD_SAMPLE_2D && rq.command != CMD_SAMPLE_1D) return;
      window(rq, x0, x1, y0, y1);
      for (int k = 0; k < NumChan; k++) sum[k] = 0;
      for (int x = x0; x <= x1; x++)
        for (int y = y0; y <= y1; y++) begin
          word = texel[y * MaxWidth + x];
          for (int k = 0; k < NumChan; k++) sum[k] += word[8*k +: 8];
        end
      n = (x1 - x0 + 1) * (y1 - y0 + 1);
      for (int k = 0; k < NumChan; k++) m.chan[k] = 16'((sum[k] * 256) / n);
      m.count = 8'(n);
      pending.push_back(m);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      errors++;
    endtask

    task check_mean(box_mean_t got);
      box_mean_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result, count %0d", got.count));
        return;
      end
      want = pending.pop_front();
      for (int k = 0; k < NumChan; k++)
        if (got.chan[k] !== want.chan[k])
          report_mismatch($sformatf("channel %0d mean %h, expected %h",
                                    k, got.chan[k], want.chan[k]));
      if (got.count !== want.count)
        report_mismatch($sformatf("pixels_counted %0d, expected %0d", got.count, want.count));
    endtask
  endclass

  logic clk;
  logic rst_n;

  bfts_item_if   item_bus ();
  bfts_result_if mean_bus ();
  bfts_cfg_if    cfg_bus ();

  box_filtered_texture_sampler_top uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_bus),
    .result_o(mean_bus),
    .cfg_i   (cfg_bus)
  );

  box_mean_board board;
  int            burst_left;
  int            sent_items;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("timeout with %0d results outstanding", board.pending.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: check every accepted mean, stall on a pattern of its own
  initial begin : mean_sink
    sink_flow_e flow;
    int         flow_left;
    box_mean_t  got;
    flow      = FLOW_OPEN;
    flow_left = 0;
    mean_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mean_bus.valid === 1'b1 && mean_bus.ready === 1'b1) begin
        got.chan[0] = mean_bus.red_avg;
        got.chan[1] = mean_bus.green_avg;
        got.chan[2] = mean_bus.blue_avg;
        got.chan[3] = mean_bus.alpha_avg;
        got.count   = mean_bus.pixels_counted;
        board.check_mean(got);
      end
      if (flow_left == 0) begin
        flow      = sink_flow_e'($urandom_range(0, 2));
        flow_left = $urandom_range(40, 500);
      end
      flow_left--;
      case (flow)
        FLOW_OPEN:  mean_bus.ready <= 1'b1;
        FLOW_LIGHT: mean_bus.ready <= ($urandom_range(0, 3) != 0);
        default:    mean_bus.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  function automatic texel_req_t random_request(input logic [1:0] cmd);
    texel_req_t rq;
    rq.command = cmd;
    rq.coord_u = 18'($urandom);
    rq.coord_v = 18'($urandom);
    rq.radius  = 3'($urandom);
    rq.pixel_x = 8'($urandom);
    rq.pixel_y = 8'($urandom);
    rq.red     = 8'($urandom);
    rq.green   = 8'($urandom);
    rq.blue    = 8'($urandom);
    rq.alpha   = 8'($urandom);
    return rq;
  endfunction

  function automatic logic signed [17:0] pick_coord(input logic signed [17:0] hot);
    int c;
    case ($urandom_range(0, 9))
      0:       c = int'(CoordMin);
      1:       c = int'(CoordMax);
      2, 3, 4: c = int'($signed(18'($urandom)));
      5, 6:    c = $urandom_range(0, 65535);
      default: c = int'(hot) + int'($urandom_range(0, 4095)) - 2048;
    endcase
    return 18'(c);
  endfunction

  // Drive one request and hold it until taken; gaps follow the end of a burst
  task automatic send_request(input texel_req_t rq);
    item_bus.valid    <= 1'b1;
    item_bus.command  <= rq.command;
    item_bus.coord_u  <= rq.coord_u;
    item_bus.coord_v  <= rq.coord_v;
    item_bus.radius   <= rq.radius;
    item_bus.pixel_x  <= rq.pixel_x;
    item_bus.pixel_y  <= rq.pixel_y;
    item_bus.red_in   <= rq.red;
    item_bus.green_in <= rq.green;
    item_bus.blue_in  <= rq.blue;
    item_bus.alpha_in <= rq.alpha;
    @(posedge clk);
    while (item_bus.ready !== 1'b1) @(posedge clk);
    board.take_request(rq);
    sent_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 20);
    end
  endtask

  task automatic write_texel(input logic [7:0] x, input logic [7:0] y,
                             input logic [31:0] rgba);
    texel_req_t rq;
    rq         = random_request(CMD_WRITE);
    rq.pixel_x = x;
    rq.pixel_y = y;
    {rq.alpha, rq.blue, rq.green, rq.red} = rgba;
    send_request(rq);
  endtask

  // Any window pixel not yet written gets a random texel first
  task automatic sample_window(input logic [1:0] cmd, input logic signed [17:0] u,
                               input logic signed [17:0] v, input logic [2:0] r);
    texel_req_t  rq;
    int unsigned holes [$];
    rq         = random_request(cmd);
    rq.coord_u = u;
    rq.coord_v = v;
    rq.radius  = r;
    board.missing_texels(rq, holes);
    foreach (holes[i]) write_texel(8'(holes[i] % MaxWidth), 8'(holes[i] / MaxWidth), $urandom);
    send_request(rq);
  endtask

  task automatic hold_until_drained(input int drain_cycles);
    int waited;
    item_bus.valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (board.pending.size() != 0 && waited < SettleLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (drain_cycles) @(posedge clk);
  endtask

  task automatic write_sizes(input logic [8:0] w, input logic [8:0] h, input bit poke_unused);
    reg_write_t writes [$];
    writes.push_back('{CFG_IMAGE_WIDTH, w});
    writes.push_back('{CFG_IMAGE_HEIGHT, h});
    if (poke_unused) writes.push_back('{CfgIdxUnused, 9'($urandom)});
    foreach (writes[i]) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= writes[i].index;
      cfg_bus.data  <= writes[i].data;
      @(posedge clk);
      while (cfg_bus.ready !== 1'b1) @(posedge clk);
      board.set_register(writes[i]);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // The budget counts every request, the writes that fill a window included
  task automatic random_phase(input int budget);
    logic signed [17:0] hot_u;
    logic signed [17:0] hot_v;
    logic signed [17:0] u;
    logic signed [17:0] v;
    logic [2:0]         r;
    logic [1:0]         cmd;
    texel_req_t         rq;
    int unsigned        holes [$];
    int                 choice;
    int                 first;
    bit                 paused;
    hot_u  = 18'($urandom_range(2048, 63487));
    hot_v  = 18'($urandom_range(2048, 63487));
    first  = sent_items;
    paused = 1'b0;
    while (sent_items - first < budget) begin
      // sender holds off mid-phase until the block has returned everything
      if (!paused && sent_items - first >= budget / 2) begin
        hold_until_drained(0);
        paused = 1'b1;
      end
      choice = $urandom_range(0, 19);
      if (choice < 14) begin
        cmd        = $urandom_range(0, 1) ? CMD_SAMPLE_2D : CMD_SAMPLE_1D;
        u          = pick_coord(hot_u);
        v          = pick_coord(hot_v);
        r          = 3'($urandom_range(0, 7));
        rq         = random_request(cmd);
        rq.coord_u = u;
        rq.coord_v = v;
        rq.radius  = r;
        board.missing_texels(rq, holes);
        // near the end of the budget a large unfilled window shrinks to one pixel
        if (holes.size() > budget - (sent_items - first)) r = 3'd0;
        sample_window(cmd, u, v, r);
      end else if (choice < 18) begin
        write_texel(8'($urandom), 8'($urandom), $urandom);
      end else begin
        send_request(random_request(CmdUnused));
      end
    end
  endtask

  initial begin : stimulus
    logic [8:0] size_w [10];
    logic [8:0] size_h [10];
    texel_req_t rq;
    board      = new();
    burst_left = 0;
    sent_items = 0;
    rst_n             <= 1'b0;
    item_bus.valid    <= 1'b0;
    item_bus.command  <= CMD_WRITE;
    item_bus.coord_u  <= '0;
    item_bus.coord_v  <= '0;
    item_bus.radius   <= '0;
    item_bus.pixel_x  <= '0;
    item_bus.pixel_y  <= '0;
    item_bus.red_in   <= '0;
    item_bus.green_in <= '0;
    item_bus.blue_in  <= '0;
    item_bus.alpha_in <= '0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= CFG_IMAGE_WIDTH;
    cfg_bus.data      <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sizes: u = 1/256 lands on column 1 only when width is 256
    write_texel(8'd0, 8'd0, 32'hFF00FF00);
    write_texel(8'd1, 8'd0, 32'h00FF00FF);
    sample_window(CMD_SAMPLE_1D, 18'sd256, CoordMin, 3'd0);
    sample_window(CMD_SAMPLE_2D, CoordMin, CoordMin, 3'd0);
    hold_until_drained(DrainCycles);

    write_sizes(9'd4, 9'd3, 1'b0);
    sample_window(CMD_SAMPLE_2D, CoordMax, CoordMax, 3'd7);
    write_texel(8'd0, 8'd0, 32'hFFFFFFFF);
    write_texel(8'd3, 8'd2, 32'h00000000);
    write_texel(8'd255, 8'd255, 32'hFFFFFFFF);
    sample_window(CMD_SAMPLE_2D, 18'sd0, 18'sd0, 3'd0);
    sample_window(CMD_SAMPLE_1D, CoordMax, CoordMax, 3'd7);
    rq         = random_request(CmdUnused);
    rq.coord_u = '1;
    rq.coord_v = '1;
    send_request(rq);
    sample_window(CMD_SAMPLE_2D, 18'sd32768, 18'sd32768, 3'd1);
    // small negative product truncates to zero, not to -1
    sample_window(CMD_SAMPLE_1D, -18'sd1, CoordMax, 3'd0);
    sample_window(CMD_SAMPLE_2D, -18'sd1, -18'sd1, 3'd7);

    size_w = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd256, 9'd1, 9'd0, 9'd0, 9'd0, 9'd0};
    size_h = '{9'd256, 9'd1, 9'd0, 9'd300, 9'd1, 9'd256, 9'd0, 9'd0, 9'd0, 9'd0};
    for (int p = 6; p < 10; p++) begin
      size_w[p] = (p == 8) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(0, 40));
      size_h[p] = (p == 8) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(0, 40));
    end
    for (int p = 0; p < 10; p++) begin
      hold_until_drained(DrainCycles);
      write_sizes(size_w[p], size_h[p], p == 3);
      random_phase(PhaseBudget);
    end

    hold_until_drained(DrainCycles);
    while (board.pending.size() != 0) begin
      board.report_mismatch("expected result never arrived");
      void'(board.pending.pop_front());
    end
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
